// File: rtl/odo_pkg.sv
`default_nettype none

package odo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int IDX_W        = $clog2(ATAN_ENTRIES);
    localparam int CW           = 33;

    localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;

    typedef logic [31:0] atan_tab_t [ATAN_ENTRIES];

    localparam atan_tab_t ATAN_TAB = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 8'd1;

    localparam logic [CFG_DATA_W-1:0] DIST_RESET = 24'd4096;
    localparam logic [CFG_DATA_W-1:0] HEAD_RESET = 24'd4096;

    // rounded Q2.22 trig value
    typedef logic signed [24:0] trig_t;

endpackage

`default_nettype wire

// File: rtl/odo_ticks_if.sv
`default_nettype none

interface odo_ticks_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_ticks;
    logic signed [15:0] left_ticks;

    modport source (output valid, output right_ticks, output left_ticks, input ready);
    modport sink   (input valid, input right_ticks, input left_ticks, output ready);
endinterface

`default_nettype wire

// File: rtl/odo_pose_if.sv
`default_nettype none

interface odo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

`default_nettype wire

// File: rtl/odo_cordic.sv
`default_nettype none

module odo_cordic
    import odo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output logic             done,
    output trig_t            cos_val,
    output trig_t            sin_val
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FIN
    } state_t;

    state_t                 state_reg;
    logic signed [CW-1:0]   x_reg;
    logic signed [CW-1:0]   y_reg;
    logic signed [CW-1:0]   z_reg;
    logic                   neg_reg;
    logic [IDX_W-1:0]       i_reg;
    logic                   done_reg;
    trig_t                  cos_reg;
    trig_t                  sin_reg;

    logic                   fold;
    logic [31:0]            angle_f;
    logic signed [CW-1:0]   xs;
    logic signed [CW-1:0]   ys;
    logic signed [CW-1:0]   at;
    logic signed [CW-1:0]   x_next;
    logic signed [CW-1:0]   y_next;
    logic signed [CW-1:0]   z_next;
    logic signed [CW-1:0]   xf;
    logic signed [CW-1:0]   yf;
    logic signed [CW-1:0]   xr;
    logic signed [CW-1:0]   yr;

    // fold into [-pi/2, pi/2): add pi, negate results later
    assign fold    = angle[31] ^ angle[30];
    assign angle_f = fold ? {~angle[31], angle[30:0]} : angle;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = CW'(signed'({1'b0, ATAN_TAB[i_reg]}));

    always_comb
    begin
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    assign xf = neg_reg ? -x_reg : x_reg;
    assign yf = neg_reg ? -y_reg : y_reg;
    assign xr = xf + CW'(128);
    assign yr = yf + CW'(128);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            neg_reg   <= 1'b0;
            i_reg     <= '0;
            done_reg  <= 1'b0;
            cos_reg   <= '0;
            sin_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= CORDIC_START;
                        y_reg     <= '0;
                        z_reg     <= CW'(signed'(angle_f));
                        neg_reg   <= fold;
                        i_reg     <= '0;
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == IDX_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= FIN;
                    end
                end
                FIN:
                begin
                    cos_reg   <= xr[CW-1:8];
                    sin_reg   <= yr[CW-1:8];
                    done_reg  <= 1'b1;
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// File: rtl/differential_drive_odometry_top.sv
// Differential-drive odometry: each ticks transaction carries signed right and left tick
// increments and yields one pose transaction (x, y, heading). Within a transaction, one
// shift-add CORDIC stage iterates once per step, and a single 26x26 multiplier forms the
// travel, the heading change and four partial products of the x/y deltas in turn.
// ticks.ready is high only between transactions; a finished pose waits in the output
// register while the next ticks transaction is taken. Write configuration only while idle.
`default_nettype none

module differential_drive_odometry_top
    import odo_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    odo_ticks_if.sink                  ticks,
    odo_pose_if.source                 pose
);

    typedef enum logic [3:0] {
        IDLE,
        MUL_S,
        MUL_D,
        ANG,
        ROT,
        XL,
        XH,
        YL,
        YH,
        UPD
    } state_t;

    state_t              state_reg;
    logic [CFG_DATA_W-1:0] dist_reg;
    logic [CFG_DATA_W-1:0] head_reg;
    logic signed [15:0]  r_reg;
    logic signed [15:0]  l_reg;
    logic signed [40:0]  s_reg;
    logic signed [40:0]  d_reg;
    trig_t               c_reg;
    trig_t               sn_reg;
    logic [63:0]         acc_reg;
    logic [31:0]         dx_reg;
    logic [31:0]         dy_reg;
    logic [31:0]         x_acc_reg;
    logic [31:0]         y_acc_reg;
    logic [15:0]         hd_acc_reg;
    logic                out_valid_reg;

    logic signed [25:0]  mul_a;
    logic signed [25:0]  mul_b;
    logic signed [51:0]  mul_p;
    logic [63:0]         prod64;
    logic [63:0]         acc_sum;
    logic [63:0]         lo_sum;
    logic signed [16:0]  tick_sum;
    logic signed [16:0]  tick_diff;
    logic [40:0]         hd_round;
    logic                cor_start;
    logic                cor_done;
    logic [31:0]         mid;
    trig_t               cor_cos;
    trig_t               cor_sin;
    trig_t               trig_sel;

    assign tick_sum  = 17'(r_reg) + 17'(l_reg);
    assign tick_diff = 17'(r_reg) - 17'(l_reg);

    always_comb
    begin
        trig_sel = ((state_reg == YL) || (state_reg == YH)) ? sn_reg : c_reg;
        case (state_reg)
            MUL_S:
            begin
                mul_a = 26'(tick_sum);
                mul_b = signed'({2'b00, dist_reg});
            end
            MUL_D:
            begin
                mul_a = 26'(tick_diff);
                mul_b = signed'({2'b00, head_reg});
            end
            XL, YL:
            begin
                mul_a = signed'({2'b00, s_reg[23:0]});
                mul_b = 26'(trig_sel);
            end
            XH, YH:
            begin
                mul_a = 26'(signed'(s_reg[40:24]));
                mul_b = 26'(trig_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod64  = 64'(mul_p);
    assign lo_sum  = prod64 + 64'h0000_0000_4000_0000;
    assign acc_sum = acc_reg + {prod64[39:0], 24'd0};

    assign mid       = {hd_acc_reg, 16'd0} + d_reg[32:1];
    assign hd_round  = d_reg + 41'sd32768;
    assign cor_start = (state_reg == ANG);

    odo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (mid),
        .done    (cor_done),
        .cos_val (cor_cos),
        .sin_val (cor_sin)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_RESET;
            head_reg <= HEAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIST: dist_reg <= cfg_wdata;
                CFG_HEAD: head_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            r_reg         <= '0;
            l_reg         <= '0;
            s_reg         <= '0;
            d_reg         <= '0;
            c_reg         <= '0;
            sn_reg        <= '0;
            acc_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            hd_acc_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && pose.ready && (state_reg != UPD))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (ticks.valid)
                    begin
                        r_reg     <= ticks.right_ticks;
                        l_reg     <= ticks.left_ticks;
                        state_reg <= MUL_S;
                    end
                end
                MUL_S:
                begin
                    s_reg     <= mul_p[40:0];
                    state_reg <= MUL_D;
                end
                MUL_D:
                begin
                    d_reg     <= mul_p[40:0];
                    state_reg <= ANG;
                end
                ANG:
                begin
                    state_reg <= ROT;
                end
                ROT:
                begin
                    if (cor_done)
                    begin
                        c_reg     <= cor_cos;
                        sn_reg    <= cor_sin;
                        state_reg <= XL;
                    end
                end
                XL:
                begin
                    acc_reg   <= lo_sum;
                    state_reg <= XH;
                end
                XH:
                begin
                    dx_reg    <= acc_sum[62:31];
                    state_reg <= YL;
                end
                YL:
                begin
                    acc_reg   <= lo_sum;
                    state_reg <= YH;
                end
                YH:
                begin
                    dy_reg    <= acc_sum[62:31];
                    state_reg <= UPD;
                end
                UPD:
                begin
                    // hold until the previous pose has left
                    if (!out_valid_reg || pose.ready)
                    begin
                        x_acc_reg     <= x_acc_reg + dx_reg;
                        y_acc_reg     <= y_acc_reg + dy_reg;
                        hd_acc_reg    <= hd_acc_reg + hd_round[31:16];
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign ticks.ready  = (state_reg == IDLE);
    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = x_acc_reg;
    assign pose.pos_y   = y_acc_reg;
    assign pose.heading = hd_acc_reg;

endmodule

`default_nettype wire
